// ===== rtl/pamhp_pkg.sv =====
`timescale 1ns / 1ps

package pamhp_pkg;

    // Width of the value accumulator and of the stored fields.
    localparam int VALUE_BITS = 32;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_GAP,
        MODE_TOKEN,
        MODE_COMMENT,
        MODE_TAIL,
        MODE_DONE
    } t_scan_mode;

    // Field selected by the last keyword, waiting for its value token.
    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_WIDTH,
        FLD_HEIGHT,
        FLD_DEPTH,
        FLD_MAXVAL,
        FLD_TUPLE
    } t_field;

    // Keyword indexes into the match flags.
    localparam int KW_COUNT    = 6;
    localparam int KW_ENDHDR   = 0;
    localparam int KW_WIDTH    = 1;
    localparam int KW_HEIGHT   = 2;
    localparam int KW_DEPTH    = 3;
    localparam int KW_MAXVAL   = 4;
    localparam int KW_TUPLTYPE = 5;

    // Keyword text, first character in the top byte, padded to eight bytes.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "ENDHDR  ", "WIDTH   ", "HEIGHT  ", "DEPTH   ", "MAXVAL  ", "TUPLTYPE"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd6, 4'd5, 4'd6, 4'd5, 4'd6, 4'd8
    };

    // Byte codes that the scanner looks for.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PRINT_LO = 8'h21;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    // Input word: one header byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
    } t_in_word;

    // Result word: the parsed header.
    typedef struct packed {
        logic signed [31:0] width_value;
        logic signed [31:0] height_value;
        logic signed [31:0] depth_value;
        logic signed [31:0] maxval_value;
        logic signed [31:0] tuple_value;
        logic [7:0]         unknown_tokens;
        logic [15:0]        header_length;
    } t_out_word;

    // Character of keyword kw at position idx.
    function automatic logic [7:0] kw_char(input logic [63:0] text, input logic [2:0] idx);
        logic [63:0] shifted;
        shifted = text << {idx, 3'b000};
        return shifted[63:56];
    endfunction

    // Low 32 bits of a stored field; the invalid marker of all ones stays all ones.
    function automatic logic [31:0] field_out(input logic [VALUE_BITS-1:0] v);
        logic [63:0] ext;
        ext = {{(64-VALUE_BITS){v[VALUE_BITS-1]}}, v};
        return ext[31:0];
    endfunction

endpackage

// ===== rtl/pam_header_parser_top.sv =====
`timescale 1ns / 1ps

// PAM header parser. Feed the header one byte per word, starting right after the
// magic line; set restart on the first byte of a new header to clear all parser
// state. The block takes one byte every clock unless stalled: each byte is handled
// combinationally by the token scanner and its effect is registered in the parser
// state registers. While a result word waits and the output is stalled, the input is
// stalled too; otherwise bytes keep flowing every cycle.
// One result word comes out per header, in the cycle after the LF that ends the
// ENDHDR line; it carries WIDTH, HEIGHT, DEPTH, MAXVAL and TUPLTYPE (0 if absent,
// -1 if malformed), the count of unknown tokens and the offset of that LF. A
// header without an ENDHDR line gives no result. Further bytes are ignored until
// restart.
module pam_header_parser_top
    import pamhp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    // Parser state.
    t_scan_mode            r_mode, n_mode;
    logic [3:0]            r_len, n_len;
    logic [KW_COUNT-1:0]   r_flags, n_flags;
    t_field                r_pend, n_pend;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic                  r_ended, n_ended;
    logic                  r_inv, n_inv;
    logic [VALUE_BITS-1:0] r_width, n_width;
    logic [VALUE_BITS-1:0] r_height, n_height;
    logic [VALUE_BITS-1:0] r_depth, n_depth;
    logic [VALUE_BITS-1:0] r_maxval, n_maxval;
    logic [VALUE_BITS-1:0] r_tuple, n_tuple;
    logic [7:0]            r_errs, n_errs;
    logic [15:0]           r_pos, n_pos;

    // Output register.
    logic      r_out_valid;
    t_out_word r_out_word;

    // State as seen by this byte, after a possible restart.
    t_scan_mode            c_mode;
    logic [3:0]            c_len;
    logic [KW_COUNT-1:0]   c_flags;
    t_field                c_pend;
    logic [VALUE_BITS-1:0] c_acc;
    logic                  c_ended;
    logic                  c_inv;
    logic [VALUE_BITS-1:0] c_width, c_height, c_depth, c_maxval, c_tuple;
    logic [7:0]            c_errs;
    logic [15:0]           c_pos;

    // Token byte path.
    logic [3:0]            b_len, t_len;
    logic [KW_COUNT-1:0]   b_flags, t_flags;
    logic [VALUE_BITS-1:0] b_acc, t_acc;
    logic                  b_ended, t_ended;
    logic                  b_inv, t_inv;
    logic [VALUE_BITS+3:0] acc_x10;
    logic [KW_COUNT-1:0]   hit;
    logic [VALUE_BITS-1:0] tok_val;

    logic [7:0] ch;
    logic       is_delim;
    logic       is_digit;
    logic       accept;
    logic       emit;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign ch         = i_in_word.data_byte;
    assign is_delim   = (ch == CH_SPACE) || (ch == CH_CR) || (ch == CH_TAB) ||
                        (ch == CH_VT) || (ch == CH_LF);
    assign is_digit   = (ch >= CH_ZERO) && (ch <= CH_NINE);

    // Restart clears everything before the byte is looked at.
    always_comb begin
        if (i_in_word.restart) begin
            c_mode   = MODE_GAP;
            c_len    = '0;
            c_flags  = '1;
            c_pend   = FLD_NONE;
            c_acc    = '0;
            c_ended  = 1'b0;
            c_inv    = 1'b0;
            c_width  = '0;
            c_height = '0;
            c_depth  = '0;
            c_maxval = '0;
            c_tuple  = '0;
            c_errs   = '0;
            c_pos    = '0;
        end else begin
            c_mode   = r_mode;
            c_len    = r_len;
            c_flags  = r_flags;
            c_pend   = r_pend;
            c_acc    = r_acc;
            c_ended  = r_ended;
            c_inv    = r_inv;
            c_width  = r_width;
            c_height = r_height;
            c_depth  = r_depth;
            c_maxval = r_maxval;
            c_tuple  = r_tuple;
            c_errs   = r_errs;
            c_pos    = r_pos;
        end
    end

    // A byte that opens a token starts from fresh token state.
    always_comb begin
        if (c_mode == MODE_GAP) begin
            b_len   = '0;
            b_flags = '1;
            b_acc   = '0;
            b_ended = 1'b0;
            b_inv   = 1'b0;
        end else begin
            b_len   = c_len;
            b_flags = c_flags;
            b_acc   = c_acc;
            b_ended = c_ended;
            b_inv   = c_inv;
        end
    end

    // Keyword compare, length count and saturating decimal accumulate for one byte.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            t_flags[k] = b_flags[k] && (b_len < KW_LEN[k]) &&
                         (kw_char(KW_TEXT[k], b_len[2:0]) == ch);
        end
        t_len   = (b_len == 4'd15) ? b_len : b_len + 4'd1;
        acc_x10 = {1'b0, b_acc, 3'b000} + {3'b000, b_acc, 1'b0} +
                  {{(VALUE_BITS){1'b0}}, ch[3:0]};
        t_acc   = b_acc;
        t_ended = b_ended;
        t_inv   = b_inv;
        if (!b_ended) begin
            if (is_digit) begin
                if (acc_x10 > {4'b0000, VALUE_MAX}) begin
                    t_acc = VALUE_MAX;
                end else begin
                    t_acc = acc_x10[VALUE_BITS-1:0];
                end
            end else begin
                t_ended = 1'b1;
                t_inv   = (ch >= CH_PRINT_LO) && (ch <= CH_PRINT_HI);
            end
        end
    end

    // Keyword hits at the end of the current token.
    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            hit[k] = c_flags[k] && (c_len == KW_LEN[k]);
        end
        tok_val = c_inv ? '1 : c_acc;
    end

    // Scanner next state.
    always_comb begin
        n_mode   = c_mode;
        n_len    = c_len;
        n_flags  = c_flags;
        n_pend   = c_pend;
        n_acc    = c_acc;
        n_ended  = c_ended;
        n_inv    = c_inv;
        n_width  = c_width;
        n_height = c_height;
        n_depth  = c_depth;
        n_maxval = c_maxval;
        n_tuple  = c_tuple;
        n_errs   = c_errs;
        n_pos    = (c_pos == 16'hFFFF) ? c_pos : c_pos + 16'd1;
        emit     = 1'b0;

        case (c_mode)
            MODE_GAP: begin
                if (is_delim) begin
                    n_mode = MODE_GAP;
                end else if (ch == CH_HASH) begin
                    n_mode = MODE_COMMENT;
                end else begin
                    n_mode  = MODE_TOKEN;
                    n_len   = t_len;
                    n_flags = t_flags;
                    n_acc   = t_acc;
                    n_ended = t_ended;
                    n_inv   = t_inv;
                end
            end
            MODE_TOKEN: begin
                if (!is_delim) begin
                    n_len   = t_len;
                    n_flags = t_flags;
                    n_acc   = t_acc;
                    n_ended = t_ended;
                    n_inv   = t_inv;
                end else if (hit[KW_ENDHDR]) begin
                    if (ch == CH_LF) begin
                        emit   = 1'b1;
                        n_mode = MODE_DONE;
                    end else begin
                        n_mode = MODE_TAIL;
                    end
                end else begin
                    // Token end: select a field, store a value, or count an error.
                    n_mode = MODE_GAP;
                    if (hit[KW_WIDTH] && c_width == '0) begin
                        n_pend = FLD_WIDTH;
                    end else if (hit[KW_HEIGHT] && c_height == '0) begin
                        n_pend = FLD_HEIGHT;
                    end else if (hit[KW_DEPTH] && c_depth == '0) begin
                        n_pend = FLD_DEPTH;
                    end else if (hit[KW_MAXVAL] && c_maxval == '0) begin
                        n_pend = FLD_MAXVAL;
                    end else if (hit[KW_TUPLTYPE]) begin
                        n_pend = FLD_TUPLE;
                    end else if (c_pend != FLD_NONE) begin
                        n_pend = FLD_NONE;
                        case (c_pend)
                            FLD_WIDTH:  n_width  = tok_val;
                            FLD_HEIGHT: n_height = tok_val;
                            FLD_DEPTH:  n_depth  = tok_val;
                            FLD_MAXVAL: n_maxval = tok_val;
                            default:    n_tuple  = tok_val;
                        endcase
                    end else if (c_errs != 8'hFF) begin
                        n_errs = c_errs + 8'd1;
                    end
                end
            end
            MODE_COMMENT: begin
                if (ch == CH_LF) begin
                    n_mode = MODE_GAP;
                end
            end
            MODE_TAIL: begin
                if (ch == CH_LF) begin
                    emit   = 1'b1;
                    n_mode = MODE_DONE;
                end
            end
            default: begin
                n_mode = c_mode;
            end
        endcase
    end

    // Parser state registers, updated on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_GAP;
            r_len    <= '0;
            r_flags  <= '1;
            r_pend   <= FLD_NONE;
            r_acc    <= '0;
            r_ended  <= 1'b0;
            r_inv    <= 1'b0;
            r_width  <= '0;
            r_height <= '0;
            r_depth  <= '0;
            r_maxval <= '0;
            r_tuple  <= '0;
            r_errs   <= '0;
            r_pos    <= '0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_len    <= n_len;
            r_flags  <= n_flags;
            r_pend   <= n_pend;
            r_acc    <= n_acc;
            r_ended  <= n_ended;
            r_inv    <= n_inv;
            r_width  <= n_width;
            r_height <= n_height;
            r_depth  <= n_depth;
            r_maxval <= n_maxval;
            r_tuple  <= n_tuple;
            r_errs   <= n_errs;
            r_pos    <= n_pos;
        end
    end

    // Result valid: set by a result, cleared once the word is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_word.width_value    <= signed'(field_out(c_width));
            r_out_word.height_value   <= signed'(field_out(c_height));
            r_out_word.depth_value    <= signed'(field_out(c_depth));
            r_out_word.maxval_value   <= signed'(field_out(c_maxval));
            r_out_word.tuple_value    <= signed'(field_out(c_tuple));
            r_out_word.unknown_tokens <= c_errs;
            r_out_word.header_length  <= c_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
